### hw/rtl/skre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skre_pkg
// Shared types, codes and constants for the sorted key/value record encoder.
// ----------------------------------------------------------------------------
package skre_pkg;

  localparam int DefMaxKeyBytes    = 64;
  localparam int DefBlockLimitLog2 = 32;
  localparam int QDepth            = 2;

  // input actions
  localparam logic [1:0] ACT_HDR    = 2'd0;
  localparam logic [1:0] ACT_KEY    = 2'd1;
  localparam logic [1:0] ACT_VAL    = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_OFFSET = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE = 3'd1;
  localparam logic [2:0] ST_SEQ      = 3'd2;
  localparam logic [2:0] ST_ORDER    = 3'd3;
  localparam logic [2:0] ST_BIG      = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // entry type codes
  localparam logic [7:0] TYPE_DEL  = 8'd0;
  localparam logic [7:0] TYPE_VAL  = 8'd1;
  localparam logic [7:0] TYPE_SDEL = 8'd7;

  // key compare progress
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // request piece positions, in emission order
  localparam int CmdBits = 18;
  localparam int M_OFF   = 0;
  localparam int M_KV0   = 1;
  localparam int M_KV1   = 2;
  localparam int M_DATA  = 3;
  localparam int M_ENT   = 4;
  localparam int M_VL    = 12;
  localparam int M_REP   = 17;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_KEY  = 3'b010,
    PH_VAL  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  key_length;
    logic [31:0] value_length;
    logic [63:0] sequence_req;
    logic [7:0]  value_type;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] entry_offset;
    logic [2:0]  status;
    logic [31:0] entry_count;
    logic [55:0] smallest_seq;
    logic [55:0] largest_seq;
    logic        last;
  } out_item_t;

  // one queued request: which pieces to emit and their data
  typedef struct packed {
    logic [CmdBits-1:0] mask;
    logic [31:0]        off;
    logic [7:0]         kv;
    logic [7:0]         dbyte;
    logic [63:0]        entry;
    logic [31:0]        vlen;
    logic [2:0]         status;
    logic [31:0]        count;
    logic [55:0]        smin;
    logic [55:0]        smax;
  } cmd_t;

  // number of varint bytes for a 32-bit value
  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] n;
    n = 3'd1;
    if (v[31:7] != '0) n = 3'd2;
    if (v[31:14] != '0) n = 3'd3;
    if (v[31:21] != '0) n = 3'd4;
    if (v[31:28] != '0) n = 3'd5;
    return n;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/skre_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skre_front
// Accepts items, runs type, range, order and size checks, keeps block state
// and turns each item into at most one request for the output serializer.
// ----------------------------------------------------------------------------
module skre_front import skre_pkg::*; #(
  parameter int MAX_KEY_BYTES    = DefMaxKeyBytes,
  parameter int BLOCK_LIMIT_LOG2 = DefBlockLimitLog2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     acc,
  input  wire in_item_t item,
  output cmd_t          cmd,
  output logic          cmd_push
);

  localparam int AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  phase_t      phase_r, phase_nxt;
  logic        sel_r, sel_nxt;
  logic [6:0]  key_index_r, key_index_nxt;
  logic [1:0]  cmp_r, cmp_nxt;
  logic [6:0]  cur_len_r, cur_len_nxt;
  logic [31:0] cur_vlen_r, cur_vlen_nxt;
  logic [63:0] cur_entry_r, cur_entry_nxt;
  logic [31:0] val_left_r, val_left_nxt;
  logic        big_r, big_nxt;
  logic [6:0]  prev_len_r, prev_len_nxt;
  logic [55:0] prev_seq_r, prev_seq_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [55:0] min_r, min_nxt;
  logic [55:0] max_r, max_nxt;
  logic [31:0] count_r, count_nxt;
  logic [32:0] bsize_r, bsize_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [7:0]  mem0 [MAX_KEY_BYTES];
  logic [7:0]  mem1 [MAX_KEY_BYTES];
  logic [7:0]  rd0_r, rd1_r;
  logic [7:0]  prev_byte;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // scratch for header, key end and commit
  logic        kd_go, kd_big, kd_bad, cm_go;
  logic [1:0]  kd_cs;
  logic [6:0]  kd_len, cm_len;
  logic [63:0] kd_entry;
  logic [31:0] kd_vlen;
  logic [55:0] cm_seq;
  logic [2:0]  nv, err_v;
  logic [7:0]  kv;
  logic [1:0]  nk;
  logic [34:0] enc, sum;
  logic [3:0]  add;
  logic [6:0]  idx_inc;

  assign prev_byte = sel_r ? rd0_r : rd1_r;
  assign wr_addr   = AW'(key_index_r);
  assign rd_addr   = AW'(key_index_nxt);

  // key stores: current bank written, previous bank read one index ahead
  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) mem0[wr_addr] <= item.data_byte;
    if (wr_en && sel_r)  mem1[wr_addr] <= item.data_byte;
    rd0_r <= mem0[rd_addr];
    rd1_r <= mem1[rd_addr];
  end

  // classify the request and compute next state
  always_comb begin
    phase_nxt     = phase_r;
    sel_nxt       = sel_r;
    key_index_nxt = key_index_r;
    cmp_nxt       = cmp_r;
    cur_len_nxt   = cur_len_r;
    cur_vlen_nxt  = cur_vlen_r;
    cur_entry_nxt = cur_entry_r;
    val_left_nxt  = val_left_r;
    big_nxt       = big_r;
    prev_len_nxt  = prev_len_r;
    prev_seq_nxt  = prev_seq_r;
    have_prev_nxt = have_prev_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    cmd           = '0;
    wr_en         = 1'b0;
    kd_go         = 1'b0;
    kd_big        = big_r;
    kd_cs         = cmp_r;
    kd_len        = cur_len_r;
    kd_entry      = cur_entry_r;
    kd_vlen       = cur_vlen_r;
    kd_bad        = 1'b0;
    cm_go         = 1'b0;
    cm_len        = cur_len_r;
    cm_seq        = cur_entry_r[63:8];
    err_v         = err_r;
    add           = 4'd0;
    idx_inc       = key_index_r + 7'd1;
    kv            = 8'(item.key_length) + 8'd8;
    nk            = kv[7] ? 2'd2 : 2'd1;
    nv            = varint_len(item.value_length);
    enc           = 35'(nk) + 35'(item.key_length) + 35'd8 + 35'(nv)
                    + 35'(item.value_length);
    sum           = {2'b00, bsize_r} + enc;
    if (acc) begin
      case (item.action)
        ACT_FINISH: begin
          if (err_r == ST_OK && phase_r != PH_IDLE) err_v = ST_ORDER;
          err_nxt = err_v;
          cmd.mask[M_REP] = 1'b1;
          if (err_v != ST_OK) begin
            cmd.status = err_v;
          end else if (count_r == '0) begin
            cmd.status = ST_EMPTY;
          end else begin
            cmd.status = ST_OK;
            cmd.count  = count_r;
            cmd.smin   = min_r;
            cmd.smax   = max_r;
            // clear block state
            phase_nxt     = PH_IDLE;
            key_index_nxt = '0;
            cmp_nxt       = CMP_EQ;
            cur_len_nxt   = '0;
            cur_vlen_nxt  = '0;
            cur_entry_nxt = '0;
            val_left_nxt  = '0;
            big_nxt       = 1'b0;
            prev_len_nxt  = '0;
            prev_seq_nxt  = '0;
            have_prev_nxt = 1'b0;
            min_nxt       = '1;
            max_nxt       = '0;
            count_nxt     = '0;
          end
        end
        ACT_HDR: begin
          if (err_r == ST_OK && phase_r == PH_IDLE) begin
            if (item.value_type != TYPE_DEL && item.value_type != TYPE_VAL &&
                item.value_type != TYPE_SDEL) begin
              err_nxt = ST_BAD_TYPE;
            end else if (item.sequence_req[63:56] != '0) begin
              err_nxt = ST_SEQ;
            end else begin
              cur_len_nxt   = item.key_length;
              cur_vlen_nxt  = item.value_length;
              cur_entry_nxt = {item.sequence_req[55:0], item.value_type};
              key_index_nxt = '0;
              cmp_nxt       = CMP_EQ;
              kd_big        = (32'(item.key_length) > 32'(MAX_KEY_BYTES)) ||
                              ((sum >> BLOCK_LIMIT_LOG2) != '0);
              big_nxt       = kd_big;
              phase_nxt     = PH_KEY;
              if (!kd_big) begin
                cmd.mask[M_OFF] = 1'b1;
                cmd.mask[M_KV0] = 1'b1;
                cmd.mask[M_KV1] = kv[7];
                cmd.off         = bsize_r[31:0];
                cmd.kv          = kv;
                add             = 4'(nk);
              end
              kd_cs    = CMP_EQ;
              kd_len   = item.key_length;
              kd_entry = {item.sequence_req[55:0], item.value_type};
              kd_vlen  = item.value_length;
              kd_go    = (item.key_length == '0);
            end
          end
        end
        ACT_KEY: begin
          if (err_r == ST_OK && phase_r == PH_KEY) begin
            if (cmp_r == CMP_EQ) begin
              if (key_index_r >= prev_len_r ||
                  32'(key_index_r) >= 32'(MAX_KEY_BYTES)) begin
                kd_cs = CMP_GT;
              end else if (item.data_byte < prev_byte) begin
                kd_cs = CMP_LT;
              end else if (item.data_byte > prev_byte) begin
                kd_cs = CMP_GT;
              end
            end
            cmp_nxt       = kd_cs;
            wr_en         = 32'(key_index_r) < 32'(MAX_KEY_BYTES);
            key_index_nxt = idx_inc;
            if (!big_r) begin
              cmd.mask[M_DATA] = 1'b1;
              cmd.dbyte        = item.data_byte;
              add              = 4'd1;
            end
            kd_go = (idx_inc >= cur_len_r);
          end
        end
        default: begin
          if (err_r == ST_OK && phase_r == PH_VAL) begin
            cmd.mask[M_DATA] = 1'b1;
            cmd.dbyte        = item.data_byte;
            add              = 4'd1;
            val_left_nxt     = val_left_r - 32'd1;
            cm_go            = (val_left_r == 32'd1);
          end
        end
      endcase
    end

    // end of key: ordering verdict, then trailer bytes
    if (kd_go) begin
      kd_bad = have_prev_r &&
               (kd_cs == CMP_LT ||
                (kd_cs == CMP_EQ && kd_len < prev_len_r) ||
                (kd_cs == CMP_EQ && kd_entry[63:8] >= prev_seq_r));
      if (kd_big) begin
        err_nxt   = kd_bad ? ST_ORDER : ST_BIG;
        phase_nxt = PH_IDLE;
      end else if (kd_bad) begin
        err_nxt   = ST_ORDER;
        phase_nxt = PH_IDLE;
      end else begin
        cmd.mask[M_ENT+7:M_ENT] = '1;
        for (int j = 0; j < 5; j++) begin
          cmd.mask[M_VL+j] = (3'(j) < varint_len(kd_vlen));
        end
        cmd.entry = kd_entry;
        cmd.vlen  = kd_vlen;
        add       = add + 4'd8 + 4'(varint_len(kd_vlen));
        if (kd_vlen == '0) begin
          cm_go  = 1'b1;
          cm_len = kd_len;
          cm_seq = kd_entry[63:8];
        end else begin
          val_left_nxt = kd_vlen;
          phase_nxt    = PH_VAL;
        end
      end
    end

    // commit entry: current key becomes previous
    if (cm_go) begin
      prev_len_nxt  = cm_len;
      prev_seq_nxt  = cm_seq;
      have_prev_nxt = 1'b1;
      if (cm_seq < min_r) min_nxt = cm_seq;
      if (cm_seq > max_r) max_nxt = cm_seq;
      count_nxt = count_r + 32'd1;
      phase_nxt = PH_IDLE;
      sel_nxt   = !sel_r;
    end

    if (acc && item.action == ACT_FINISH && err_v == ST_OK && count_r != '0) begin
      bsize_nxt = '0;
    end else begin
      bsize_nxt = bsize_r + 33'(add);
    end
    cmd_push = acc && (cmd.mask != '0);
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sel_r       <= 1'b0;
      key_index_r <= '0;
      cmp_r       <= CMP_EQ;
      cur_len_r   <= '0;
      cur_vlen_r  <= '0;
      cur_entry_r <= '0;
      val_left_r  <= '0;
      big_r       <= 1'b0;
      prev_len_r  <= '0;
      prev_seq_r  <= '0;
      have_prev_r <= 1'b0;
      min_r       <= '1;
      max_r       <= '0;
      count_r     <= '0;
      bsize_r     <= '0;
      err_r       <= ST_OK;
    end else begin
      phase_r     <= phase_nxt;
      sel_r       <= sel_nxt;
      key_index_r <= key_index_nxt;
      cmp_r       <= cmp_nxt;
      cur_len_r   <= cur_len_nxt;
      cur_vlen_r  <= cur_vlen_nxt;
      cur_entry_r <= cur_entry_nxt;
      val_left_r  <= val_left_nxt;
      big_r       <= big_nxt;
      prev_len_r  <= prev_len_nxt;
      prev_seq_r  <= prev_seq_nxt;
      have_prev_r <= have_prev_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      count_r     <= count_nxt;
      bsize_r     <= bsize_nxt;
      err_r       <= err_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/skre_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skre_queue
// Short request queue between the classifier and the output serializer.
// ----------------------------------------------------------------------------
module skre_queue import skre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd,
  input  wire logic pop
);

  localparam int PW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cmd_t                entries_r [QDepth];
  logic [PW-1:0]       wp_r, rp_r;
  logic [$clog2(QDepth+1)-1:0] cnt_r;

  assign full       = (32'(cnt_r) == 32'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = entries_r[rp_r];

  // store pushed requests
  always_ff @(posedge clk) begin
    if (push) entries_r[wp_r] <= push_cmd;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (32'(wp_r) == QDepth - 1) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (32'(rp_r) == QDepth - 1) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/skre_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skre_back
// Output serializer: expands each request into result items, one per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module skre_back import skre_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  head_valid,
  input  wire cmd_t  head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item
);

  logic [CmdBits-1:0] cur_mask_r;
  cmd_t               cur_cmd_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               use_q, can, go;
  logic [CmdBits-1:0] act_mask, low, rest;
  cmd_t               act;
  logic [4:0]         idx;
  logic [2:0]         k;
  logic [31:0]        vsh;
  out_item_t          res;

  assign use_q    = (cur_mask_r == '0);
  assign act_mask = use_q ? (head_valid ? head_cmd.mask : '0) : cur_mask_r;
  assign act      = use_q ? head_cmd : cur_cmd_r;
  assign low      = act_mask & (~act_mask + 1'b1);
  assign rest     = act_mask & ~low;
  assign can      = !out_valid_r || !out_stall;
  assign go       = can && (act_mask != '0);
  assign pop      = go && use_q;

  // encode the lowest pending piece
  always_comb begin
    idx = '0;
    for (int i = 0; i < CmdBits; i++) begin
      if (low[i]) idx = 5'(i);
    end
  end

  // build the result for the selected piece
  always_comb begin
    res  = '0;
    k    = 3'(idx - 5'(M_ENT));
    vsh  = act.vlen >> (7 * 32'(3'(idx - 5'(M_VL))));
    res.last = (rest == '0);
    case (idx) inside
      5'(M_OFF): begin
        res.kind         = KIND_OFFSET;
        res.entry_offset = act.off;
      end
      5'(M_KV0): begin
        res.out_byte = {rest[M_KV1], act.kv[6:0]};
      end
      5'(M_KV1): begin
        res.out_byte = {7'd0, act.kv[7]};
      end
      5'(M_DATA): begin
        res.out_byte = act.dbyte;
      end
      [5'(M_ENT):5'(M_ENT+7)]: begin
        res.out_byte = act.entry[8*k +: 8];
      end
      [5'(M_VL):5'(M_VL+4)]: begin
        res.out_byte = {(rest[M_VL+4:M_VL] != '0), vsh[6:0]};
      end
      default: begin
        res.kind         = KIND_REPORT;
        res.status       = act.status;
        res.entry_count  = act.count;
        res.smallest_seq = act.smin;
        res.largest_seq  = act.smax;
      end
    endcase
  end

  // hold the request being expanded and drop pieces as they go
  always_ff @(posedge clk) begin
    if (go && use_q) cur_cmd_r <= head_cmd;
    if (go) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) cur_mask_r <= rest;
      if (go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

### hw/rtl/sorted_kv_record_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_kv_record_encoder_core
// Memtable entry encoder: key/value items in, encoded block bytes out.
// ----------------------------------------------------------------------------
// Usage: send a header, its key bytes and its value bytes, then finish. Each
// input request is classified as soon as it is taken; key and value bytes
// stream at one per cycle while the input is not stalled. The output
// serializer sends one result per cycle while out_stall is low, so a header
// that ends its key expands to up to 15 results (offset, length varint,
// eight sequence/type bytes, value length varint), and the input stalls
// while the two-entry request queue is full. After an error, downstream must
// drop the block: bytes already sent are not recalled.
module sorted_kv_record_encoder_core import skre_pkg::*; #(
  parameter int MAX_KEY_BYTES    = DefMaxKeyBytes,
  parameter int BLOCK_LIMIT_LOG2 = DefBlockLimitLog2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic acc, push, full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  // classify requests
  skre_front #(
    .MAX_KEY_BYTES   (MAX_KEY_BYTES),
    .BLOCK_LIMIT_LOG2(BLOCK_LIMIT_LOG2)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .item    (in_item),
    .cmd     (push_cmd),
    .cmd_push(push)
  );

  // buffer requests
  skre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  // expand requests into results
  skre_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

### sim/skre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skre_checker
// Watches both channels of the record encoder, predicts every encoded byte,
// entry offset and finish report, and compares each result in order.
// ----------------------------------------------------------------------------
module skre_checker import skre_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  localparam int KeyMax = DefMaxKeyBytes;
  localparam logic [55:0] SeqMax = '1;

  // predictor copy of the encoder state
  logic [7:0]  prev_key [KeyMax];
  logic [7:0]  cur_key [KeyMax];
  int unsigned prev_key_len;
  logic [55:0] prev_seq;
  bit          have_prev;
  logic [55:0] min_seq, max_seq;
  logic [31:0] entry_total;
  longint unsigned block_bytes;
  logic [2:0]  sticky_err;
  logic [1:0]  cmp_st;
  int unsigned key_pos;
  logic [63:0] cur_entry;
  logic [1:0]  entry_phase; // ACT_HDR idle, ACT_KEY key, ACT_VAL value
  int unsigned cur_klen;
  logic [31:0] cur_vlen, val_left;
  bit          big_pending;

  out_item_t encoded_q[$];
  out_item_t step_q[$];
  int errs;

  assign fail_count = errs;
  assign pending    = encoded_q.size();

  task automatic clear_state();
    prev_key_len = 0; prev_seq = '0; have_prev = 0;
    min_seq = SeqMax; max_seq = '0; entry_total = '0; block_bytes = 0;
    sticky_err = ST_OK; cmp_st = CMP_EQ; key_pos = 0; cur_entry = '0;
    entry_phase = ACT_HDR; cur_klen = 0; cur_vlen = '0; val_left = '0;
    big_pending = 0;
  endtask

  task automatic put_result(logic [1:0] k, logic [7:0] b, logic [31:0] off,
                            logic [2:0] st, logic [31:0] cnt,
                            logic [55:0] smin, logic [55:0] smax);
    out_item_t r;
    r = '{kind: k, out_byte: b, entry_offset: off, status: st,
          entry_count: cnt, smallest_seq: smin, largest_seq: smax, last: 1'b0};
    step_q.insert(step_q.size(), r);
  endtask

  task automatic put_byte(logic [7:0] b);
    put_result(KIND_BYTE, b, '0, ST_OK, '0, '0, '0);
    block_bytes++;
  endtask

  task automatic put_varint(logic [31:0] v);
    while (v >= 32'h80) begin
      put_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    put_byte(v[7:0]);
  endtask

  function automatic longint unsigned varint_bytes(logic [31:0] v);
    longint unsigned n;
    n = 1;
    while (v >= 32'h80) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  function automatic bit order_fails();
    logic [1:0] cs;
    if (!have_prev) return 0;
    cs = cmp_st;
    if (cs == CMP_EQ && cur_klen < prev_key_len) cs = CMP_LT;
    return cs == CMP_LT || (cs == CMP_EQ && cur_entry[63:8] >= prev_seq);
  endfunction

  task automatic commit_entry();
    logic [55:0] s;
    s = cur_entry[63:8];
    for (int i = 0; i < cur_klen && i < KeyMax; i++) prev_key[i] = cur_key[i];
    prev_key_len = cur_klen;
    prev_seq = s;
    have_prev = 1;
    if (s < min_seq) min_seq = s;
    if (s > max_seq) max_seq = s;
    entry_total++;
    entry_phase = ACT_HDR;
  endtask

  task automatic end_of_key();
    if (big_pending) begin
      sticky_err = order_fails() ? ST_ORDER : ST_BIG;
      entry_phase = ACT_HDR;
    end else if (order_fails()) begin
      sticky_err = ST_ORDER;
      entry_phase = ACT_HDR;
    end else begin
      for (int i = 0; i < 8; i++) put_byte(cur_entry[8*i +: 8]);
      put_varint(cur_vlen);
      if (cur_vlen == 0) commit_entry();
      else begin
        val_left = cur_vlen;
        entry_phase = ACT_VAL;
      end
    end
  endtask

  // work out the results caused by one accepted request
  task automatic encode_request(in_item_t it);
    longint unsigned enc;
    out_item_t tail;
    step_q.delete();
    if (it.action == ACT_FINISH) begin
      if (sticky_err == ST_OK && entry_phase != ACT_HDR) sticky_err = ST_ORDER;
      if (sticky_err != ST_OK) put_result(KIND_REPORT, '0, '0, sticky_err, '0, '0, '0);
      else if (entry_total == 0) put_result(KIND_REPORT, '0, '0, ST_EMPTY, '0, '0, '0);
      else begin
        put_result(KIND_REPORT, '0, '0, ST_OK, entry_total, min_seq, max_seq);
        clear_state();
      end
    end else if (sticky_err != ST_OK) begin
      // sticky error: drop everything but finish
    end else if (it.action == ACT_HDR) begin
      if (entry_phase != ACT_HDR) begin
        // header inside an open entry: drop
      end else if (it.value_type != TYPE_DEL && it.value_type != TYPE_VAL &&
                   it.value_type != TYPE_SDEL) begin
        sticky_err = ST_BAD_TYPE;
      end else if (it.sequence_req > {8'h00, SeqMax}) begin
        sticky_err = ST_SEQ;
      end else begin
        enc = varint_bytes(it.key_length + 32'd8) + it.key_length + 8 +
              varint_bytes(it.value_length) + it.value_length;
        cur_klen = it.key_length;
        cur_vlen = it.value_length;
        cur_entry = {it.sequence_req[55:0], it.value_type};
        key_pos = 0;
        cmp_st = CMP_EQ;
        big_pending = (it.key_length > KeyMax) ||
                      (block_bytes + enc >= (64'd1 << DefBlockLimitLog2));
        entry_phase = ACT_KEY;
        if (!big_pending) begin
          put_result(KIND_OFFSET, '0, block_bytes[31:0], ST_OK, '0, '0, '0);
          put_varint(it.key_length + 32'd8);
        end
        if (it.key_length == 0) end_of_key();
      end
    end else if (it.action == ACT_KEY) begin
      if (entry_phase == ACT_KEY) begin
        if (cmp_st == CMP_EQ) begin
          if (key_pos >= prev_key_len || key_pos >= KeyMax) cmp_st = CMP_GT;
          else if (it.data_byte < prev_key[key_pos]) cmp_st = CMP_LT;
          else if (it.data_byte > prev_key[key_pos]) cmp_st = CMP_GT;
        end
        if (key_pos < KeyMax) cur_key[key_pos] = it.data_byte;
        key_pos++;
        if (!big_pending) put_byte(it.data_byte);
        if (key_pos >= cur_klen) end_of_key();
      end
    end else begin
      if (entry_phase == ACT_VAL) begin
        put_byte(it.data_byte);
        val_left--;
        if (val_left == 0) commit_entry();
      end
    end
    if (step_q.size() > 0) begin
      tail = step_q[step_q.size() - 1];
      tail.last = 1'b1;
      step_q[step_q.size() - 1] = tail;
    end
    foreach (step_q[i]) encoded_q.insert(encoded_q.size(), step_q[i]);
  endtask

  function automatic void check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errs++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
    end
  endfunction

  initial begin
    errs = 0;
    clear_state();
  end

  // compare results, then predict the request taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_state();
      encoded_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (encoded_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_item);
        end else begin
          want = encoded_q.pop_front();
          check_field("kind", want.kind, out_item.kind);
          check_field("out_byte", want.out_byte, out_item.out_byte);
          check_field("entry_offset", want.entry_offset, out_item.entry_offset);
          check_field("status", want.status, out_item.status);
          check_field("entry_count", want.entry_count, out_item.entry_count);
          check_field("smallest_seq", want.smallest_seq, out_item.smallest_seq);
          check_field("largest_seq", want.largest_seq, out_item.largest_seq);
          check_field("last", want.last, out_item.last);
        end
      end
      if (in_valid && !in_stall) encode_request(in_item);
    end
  end

endmodule

### sim/sorted_kv_record_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_kv_record_encoder_core_tb
// Drives ordered key/value blocks with stray requests, random gaps and a long
// output hold; ends the run with one randomly chosen error case.
// ----------------------------------------------------------------------------
module sorted_kv_record_encoder_core_tb;
  import skre_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count, pending;

  bit hold_req = 0, hold_done = 0;
  int hold_left = 0, stall_left = 0, calm_left = 0;
  int req_count = 0;
  logic [7:0] key_buf [128];
  logic [7:0] last_key [64];
  int last_klen = 0;

  sorted_kv_record_encoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  skre_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, calm stretches and one long hold
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      if (r < 3) calm_left <= 150;
      else if (r < 4) stall_left <= $urandom_range(10, 40);
      else if (r < 35) stall_left <= $urandom_range(0, 2);
    end
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.key_length = 7'($urandom);
    it.value_length = $urandom;
    it.sequence_req = {$urandom, $urandom};
    it.value_type = 8'($urandom);
    it.data_byte = 8'($urandom);
    return it;
  endfunction

  // offer one request and hold it until taken
  task automatic send(in_item_t it);
    int r, g;
    r = $urandom_range(0, 99);
    g = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    req_count++;
  endtask

  task automatic send_data(logic [1:0] act, logic [7:0] b);
    in_item_t it;
    it = noise_item();
    it.action = act;
    it.data_byte = b;
    send(it);
  endtask

  // stray request that the encoder must drop in the current entry phase
  task automatic send_stray(logic [1:0] act);
    in_item_t it;
    it = noise_item();
    it.action = act;
    send(it);
  endtask

  task automatic send_finish();
    in_item_t it;
    it = noise_item();
    it.action = ACT_FINISH;
    send(it);
  endtask

  // header, key bytes from key_buf, then value bytes if asked
  task automatic send_entry(int kl, logic [31:0] vl, logic [63:0] sq,
                            logic [7:0] ty, bit stream_val, bit strays);
    in_item_t it;
    it = noise_item();
    it.action = ACT_HDR;
    it.key_length = 7'(kl);
    it.value_length = vl;
    it.sequence_req = sq;
    it.value_type = ty;
    send(it);
    for (int i = 0; i < kl; i++) begin
      if (strays && $urandom_range(0, 19) == 0)
        send_stray($urandom_range(0, 1) ? ACT_VAL : ACT_HDR);
      send_data(ACT_KEY, key_buf[i]);
    end
    if (stream_val) begin
      for (longint i = 0; i < vl; i++) begin
        if (strays && $urandom_range(0, 19) == 0)
          send_stray($urandom_range(0, 1) ? ACT_KEY : ACT_HDR);
        send_data(ACT_VAL, 8'($urandom));
      end
    end
    for (int i = 0; i < kl && i < 64; i++) last_key[i] = key_buf[i];
    last_klen = kl;
  endtask

  // bytewise compare of key_buf against the last key sent
  function automatic int key_cmp(int kl);
    for (int i = 0; i < kl && i < last_klen; i++) begin
      if (key_buf[i] < last_key[i]) return -1;
      if (key_buf[i] > last_key[i]) return 1;
    end
    return (kl < last_klen) ? -1 : (kl > last_klen) ? 1 : 0;
  endfunction

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? TYPE_DEL : (r == 1) ? TYPE_VAL : TYPE_SDEL;
  endfunction

  initial begin
    logic [55:0] seq;
    int kl, n, r, sc;
    logic [31:0] vl;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty finish, extreme sequences, all types, long key
    send_finish();
    last_klen = 0;
    send_entry(0, 0, {8'h00, {56{1'b1}}}, TYPE_DEL, 1, 0);
    key_buf[0] = 8'h00;
    send_entry(1, 1, 64'd5, TYPE_VAL, 1, 0);
    key_buf[0] = 8'hff;
    send_entry(1, 130, 64'd0, TYPE_SDEL, 1, 0);
    for (int i = 0; i < 64; i++) key_buf[i] = 8'hff;
    send_entry(64, 0, 64'd3, TYPE_VAL, 1, 0);
    send_stray(ACT_KEY);
    send_stray(ACT_VAL);
    send_finish();
    last_klen = 0;

    // random ordered blocks with strays
    while (req_count < 500) begin
      if (!hold_req && req_count > 200) hold_req = 1;
      n = $urandom_range(1, 6);
      seq = 56'({$urandom, $urandom});
      if (seq < 56'd100000) seq = seq + 56'd100000;
      for (int e = 0; e < n; e++) begin
        r = $urandom_range(0, 99);
        kl = (r < 90) ? $urandom_range(0, 6) : $urandom_range(7, 64);
        for (int i = 0; i < kl; i++) key_buf[i] = 8'($urandom);
        if (key_cmp(kl) < 0) begin
          kl = last_klen;
          for (int i = 0; i < kl; i++) key_buf[i] = last_key[i];
        end
        seq = seq - 56'($urandom_range(1, 1000));
        r = $urandom_range(0, 99);
        vl = (r < 80) ? $urandom_range(0, 4) : (r < 96) ? $urandom_range(5, 20)
                                                       : $urandom_range(128, 300);
        send_entry(kl, vl, {8'h00, seq}, pick_type(), 1, 1);
        if ($urandom_range(0, 9) == 0) send_stray($urandom_range(0, 1) ? ACT_KEY : ACT_VAL);
      end
      send_finish();
      last_klen = 0;
    end

    // one sticky error case per run, then dropped requests
    sc = $urandom_range(0, 5);
    kl = $urandom_range(1, 4);
    for (int i = 0; i < 128; i++) key_buf[i] = 8'($urandom);
    case (sc)
      0: send_entry(kl, 1, 64'd10, 8'd2 + 8'($urandom_range(0, 4)), 1, 0);
      1: send_entry(kl, 1, {8'd1 + 8'($urandom_range(0, 254)), 32'($urandom),
                            24'($urandom)}, TYPE_VAL, 1, 0);
      2: begin
        send_entry(kl, 0, 64'd100, TYPE_VAL, 1, 0);
        send_entry(kl, 2, 64'd200, TYPE_VAL, 1, 0);
      end
      3: send_entry($urandom_range(65, 127), 0, 64'd7, TYPE_DEL, 1, 0);
      4: send_entry(kl, 32'hffff_ffff - $urandom_range(0, 50), 64'd7, TYPE_VAL, 0, 0);
      default: send_entry(kl, $urandom_range(32'h1000_0000, 32'h8000_0000),
                          64'd7, TYPE_SDEL, 0, 0);
    endcase
    repeat (10) send(noise_item());
    send_finish();
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
